// ===== hw/rtl/bre_pkg.sv =====
// Shared types and constants for the byte run-length encoder.
`timescale 1ns / 1ps

package bre_pkg;

  // Longest run held in one pair
  localparam logic [7:0] RUN_MAX = 8'd255;

  // Pair queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Number of pairs written by the front in one cycle
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic       no_gain;
    logic       last_pair;
    logic [7:0] run_value;
    logic [7:0] run_count;
  } pair_t;

  // Pairs handed from front to back; e0 is written first
  typedef struct packed {
    logic [1:0] n;
    pair_t      e0;
    pair_t      e1;
  } push_t;

endpackage

// ===== hw/rtl/bre_front.sv =====
// Front part: takes bytes, tracks the open run and the byte counters, emits pairs.
`timescale 1ns / 1ps

module bre_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] byte_value
  input  logic           in_tlast,
  input  logic           space_ok,
  output bre_pkg::push_t push
);

  logic [7:0]             run_byte_r,   run_byte_nxt;
  logic [7:0]             run_length_r, run_length_nxt;
  logic                   run_open_r,   run_open_nxt;
  logic [COUNT_WIDTH-1:0] bytes_in_r,   bytes_in_nxt;
  logic [COUNT_WIDTH-1:0] bytes_out_r,  bytes_out_nxt;

  logic                   acc;
  logic                   extend;
  logic                   close;
  logic [7:0]             new_length;
  logic [2:0]             fin_step;
  logic [COUNT_WIDTH:0]   bin_sum;
  logic [COUNT_WIDTH:0]   bcl_sum;
  logic [COUNT_WIDTH:0]   bfin_sum;
  logic [COUNT_WIDTH-1:0] bin_sat;
  logic [COUNT_WIDTH-1:0] bcl_sat;
  logic [COUNT_WIDTH-1:0] bfin_sat;
  bre_pkg::pair_t         closed_pair;
  bre_pkg::pair_t         final_pair;

  // Accept only while the queue can take two pairs
  assign in_tready = space_ok;
  assign acc       = in_tvalid & space_ok;

  // Classify the byte against the open run
  assign extend     = run_open_r && (in_tdata == run_byte_r) && (run_length_r != bre_pkg::RUN_MAX);
  assign close      = run_open_r && !extend;
  assign new_length = extend ? (run_length_r + 8'd1) : 8'd1;

  // Saturating counters: carry out of the add means saturate
  assign bin_sum  = {1'b0, bytes_in_r} + (COUNT_WIDTH+1)'(1);
  assign bcl_sum  = {1'b0, bytes_out_r} + (COUNT_WIDTH+1)'(2);
  assign fin_step = close ? 3'd4 : 3'd2;
  assign bfin_sum = {1'b0, bytes_out_r} + (COUNT_WIDTH+1)'(fin_step);

  assign bin_sat  = bin_sum[COUNT_WIDTH]  ? '1 : bin_sum[COUNT_WIDTH-1:0];
  assign bcl_sat  = bcl_sum[COUNT_WIDTH]  ? '1 : bcl_sum[COUNT_WIDTH-1:0];
  assign bfin_sat = bfin_sum[COUNT_WIDTH] ? '1 : bfin_sum[COUNT_WIDTH-1:0];

  // Build the pairs this byte causes
  always_comb begin
    closed_pair.run_count = run_length_r;
    closed_pair.run_value = run_byte_r;
    closed_pair.last_pair = 1'b0;
    closed_pair.no_gain   = 1'b0;

    final_pair.run_count  = new_length;
    final_pair.run_value  = in_tdata;
    final_pair.last_pair  = 1'b1;
    final_pair.no_gain    = (bfin_sat >= bin_sat);
  end

  always_comb begin
    push.e0 = close ? closed_pair : final_pair;
    push.e1 = final_pair;
    push.n  = bre_pkg::PUSH_NONE;
    if (acc) begin
      if (close && in_tlast) begin
        push.n = bre_pkg::PUSH_TWO;
      end else if (close || in_tlast) begin
        push.n = bre_pkg::PUSH_ONE;
      end
    end
  end

  // Advance the run state; the end of a buffer clears everything
  always_comb begin
    run_byte_nxt   = run_byte_r;
    run_length_nxt = run_length_r;
    run_open_nxt   = run_open_r;
    bytes_in_nxt   = bytes_in_r;
    bytes_out_nxt  = bytes_out_r;
    if (acc) begin
      if (in_tlast) begin
        run_byte_nxt   = 8'd0;
        run_length_nxt = 8'd0;
        run_open_nxt   = 1'b0;
        bytes_in_nxt   = '0;
        bytes_out_nxt  = '0;
      end else begin
        run_byte_nxt   = in_tdata;
        run_length_nxt = new_length;
        run_open_nxt   = 1'b1;
        bytes_in_nxt   = bin_sat;
        bytes_out_nxt  = close ? bcl_sat : bytes_out_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r   <= 8'd0;
      run_length_r <= 8'd0;
      run_open_r   <= 1'b0;
      bytes_in_r   <= '0;
      bytes_out_r  <= '0;
    end else begin
      run_byte_r   <= run_byte_nxt;
      run_length_r <= run_length_nxt;
      run_open_r   <= run_open_nxt;
      bytes_in_r   <= bytes_in_nxt;
      bytes_out_r  <= bytes_out_nxt;
    end
  end

endmodule

// ===== hw/rtl/bre_back.sv =====
// Back part: pair queue and output register towards the result stream.
`timescale 1ns / 1ps

module bre_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bre_pkg::push_t push,
  output logic           space_ok,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,  // [7:0] run_count, [15:8] run_value
  output logic           out_tlast,
  output logic           out_tuser   // [0] no_gain
);

  bre_pkg::pair_t             q_r [bre_pkg::QDEPTH];
  logic [bre_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bre_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bre_pkg::QCW-1:0]    cnt_r,    cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bre_pkg::pair_t             out_pair_r;
  logic                       pop;

  // Front may write two pairs only when two slots are free
  assign space_ok = (cnt_r <= bre_pkg::QCW'(bre_pkg::QDEPTH - 2));

  // Load the output register when it is empty or being taken
  assign pop = (cnt_r != '0) && (!out_valid_r || out_tready);

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r + bre_pkg::QAW'(push.n);
    rd_ptr_nxt    = rd_ptr_r + bre_pkg::QAW'(pop);
    cnt_nxt       = cnt_r + bre_pkg::QCW'(push.n) - bre_pkg::QCW'(pop);
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Write up to two pairs in order
  always_ff @(posedge clk) begin
    if (push.n != bre_pkg::PUSH_NONE) begin
      q_r[wr_ptr_r] <= push.e0;
    end
    if (push.n == bre_pkg::PUSH_TWO) begin
      q_r[wr_ptr_r + bre_pkg::QAW'(1)] <= push.e1;
    end
  end

  // Move the head pair into the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_pair_r <= q_r[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pair_r.run_value, out_pair_r.run_count};
  assign out_tlast  = out_pair_r.last_pair;
  assign out_tuser  = out_pair_r.no_gain;

  // Queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bre_pkg::QCW'(bre_pkg::QDEPTH))
    else $error("pair queue overfilled");

  // Pairs are written only when the front was told there is room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != bre_pkg::PUSH_NONE) |-> space_ok)
    else $error("pair written without room");

  // no_gain appears only on the final pair of a buffer
  a_gain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pair_r.no_gain) |-> out_pair_r.last_pair)
    else $error("no_gain on a pair that is not last");

  // A delivered pair never has a zero count
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pair_r.run_count != 8'd0))
    else $error("pair with zero run count");

endmodule

// ===== hw/rtl/byte_run_length_encoder_unit.sv =====
// Top level of the byte run-length encoder: front classifier and back pair queue.
`timescale 1ns / 1ps

// Takes one byte per cycle on the in_ stream while in_tready is high (tlast
// marks the last byte of a buffer) and delivers (count, value) pairs on the
// out_ stream, one per cycle while out_tready is high; the final pair of a
// buffer carries tlast, and tuser raises no_gain when the encoded size is not
// below the input size. Sustained rate is one byte per cycle while out_tready
// stays high. A byte that both closes a run and ends the buffer writes two
// pairs into the four-entry pair queue at once; in_tready drops whenever fewer
// than two queue slots are free, so input waits for the back to drain pairs. A
// pair enters the queue when its byte is accepted and then moves to the output
// register driving out_. Byte counters are COUNT_WIDTH bits wide and saturate.

module byte_run_length_encoder_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] run_count, [15:8] run_value
  output logic        out_tlast,  // last_pair
  output logic        out_tuser   // [0] no_gain
);

  bre_pkg::push_t push;
  logic           space_ok;

  bre_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .space_ok  (space_ok),
    .push      (push)
  );

  bre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
